// ----- hdl/rgb_to_printable_char_encoder_assert.svh -----
// Assertion macros shared by the encoder modules.
`ifndef RGB_TO_PRINTABLE_CHAR_ENCODER_ASSERT_SVH
`define RGB_TO_PRINTABLE_CHAR_ENCODER_ASSERT_SVH

// Same-cycle implication, checked on clk and quiet during rst.
`define RTPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and quiet during rst.
`define RTPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/rtpc_pkg.sv -----
// Package: types, constants and helpers of the RGB to printable character encoder.
package rtpc_pkg;

  localparam logic [7:0] CHAR_OFFSET = 8'd33;
  localparam logic [7:0] QUOTE_CHAR = 8'h22;
  localparam logic [7:0] BACKSLASH_CHAR = 8'h5C;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] TAB_CHAR = 8'h09;
  localparam logic [7:0] DEFAULT_PIXELS_PER_LINE = 8'd16;

  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] LAST_GROUP = 2'd3;
  localparam logic [1:0] LAST_BREAK = 2'd3;

  // One classified pixel: four characters, their escape flags, break flag.
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [3:0]      esc;
    logic            brk;
  } job_t;

  // Queue status seen by the front and back ends.
  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

  function automatic logic [7:0] break_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = QUOTE_CHAR;
      2'd1:    ch = NEWLINE_CHAR;
      2'd2:    ch = TAB_CHAR;
      default: ch = QUOTE_CHAR;
    endcase
    return ch;
  endfunction

endpackage

// ----- hdl/rtpc_if.sv -----
// Channel interfaces: pixel input, character output and configuration write.
interface rtpc_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       image_start;
  modport source (output valid, red, green, blue, image_start, input ready);
  modport sink (input valid, red, green, blue, image_start, output ready);
endinterface

interface rtpc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_of_pixel;
  modport source (output valid, out_char, last_of_pixel, input ready);
  modport sink (input valid, out_char, last_of_pixel, output ready);
endinterface

interface rtpc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- hdl/rtpc_front.sv -----
// Front end: accept pixels, split into characters, mark escapes and line breaks.
module rtpc_front import rtpc_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  rtpc_pixel_if.sink     pixels,
  rtpc_cfg_if.sink       cfg,
  input  queue_status_t  q_status,
  output logic           push,
  output job_t           push_job
);

  logic [7:0]  pixels_per_line;
  logic [7:0]  line_pixel_count;
  logic [7:0]  count_base;
  logic [7:0]  count_inc;
  logic [23:0] pix;

  assign cfg.ready = 1'b1;
  assign pixels.ready = !q_status.full;
  assign push = pixels.valid && pixels.ready;

  assign pix = {pixels.red, pixels.green, pixels.blue};
  assign count_base = pixels.image_start ? 8'd0 : line_pixel_count;
  assign count_inc = count_base + 8'd1;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      push_job.chars[k] = {2'b00, pix[18 - 6 * k +: 6]} + CHAR_OFFSET;
      push_job.esc[k] = (push_job.chars[k] == QUOTE_CHAR) ||
                        (push_job.chars[k] == BACKSLASH_CHAR);
    end
    push_job.brk = (count_inc >= pixels_per_line);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixels_per_line <= DEFAULT_PIXELS_PER_LINE;
      line_pixel_count <= 8'd0;
    end else begin
      if (cfg.valid) begin
        pixels_per_line <= cfg.data;
      end
      if (push) begin
        line_pixel_count <= push_job.brk ? 8'd0 : count_inc;
      end
    end
  end

endmodule

// ----- hdl/rtpc_queue.sv -----
// Short job queue between the front and back ends.
`include "rgb_to_printable_char_encoder_assert.svh"
module rtpc_queue import rtpc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  job_t          push_job,
  input  logic          pop,
  output job_t          head_job,
  output queue_status_t q_status
);

  job_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_status.valid = (count != '0);
  assign q_status.full = (count == CNT_W'(QUEUE_DEPTH));
  assign head_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `RTPC_ASSERT_NOW(a_no_push_full, q_status.full, !push, "push into a full queue")
  `RTPC_ASSERT_NOW(a_no_pop_empty, !q_status.valid, !pop, "pop from an empty queue")
  `RTPC_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + CNT_W'(1), "queue count did not advance")

endmodule

// ----- hdl/rtpc_back.sv -----
// Back end: sequence the bytes of each queued pixel into the output register.
`include "rgb_to_printable_char_encoder_assert.svh"
module rtpc_back import rtpc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  job_t          head_job,
  input  queue_status_t q_status,
  output logic          pop,
  rtpc_char_if.source   chars
);

  logic [1:0] grp;
  logic       esc_done;
  logic       in_break;
  logic [1:0] brk_idx;

  logic       load;
  logic [7:0] byte_next;
  logic       last_next;
  logic [7:0] cur_char;

  assign load = q_status.valid && (!chars.valid || chars.ready);
  assign cur_char = head_job.chars[grp];

  always_comb begin
    byte_next = cur_char;
    last_next = 1'b0;
    pop = 1'b0;
    if (in_break) begin
      byte_next = break_char(brk_idx);
      if (brk_idx == LAST_BREAK) begin
        last_next = 1'b1;
        pop = load;
      end
    end else if (head_job.esc[grp] && !esc_done) begin
      byte_next = BACKSLASH_CHAR;
    end else if (grp == LAST_GROUP && !head_job.brk) begin
      last_next = 1'b1;
      pop = load;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grp <= 2'd0;
      esc_done <= 1'b0;
      in_break <= 1'b0;
      brk_idx <= 2'd0;
      chars.valid <= 1'b0;
    end else begin
      if (load) begin
        chars.valid <= 1'b1;
        if (in_break) begin
          if (brk_idx == LAST_BREAK) begin
            in_break <= 1'b0;
            brk_idx <= 2'd0;
            grp <= 2'd0;
          end else begin
            brk_idx <= brk_idx + 2'd1;
          end
        end else if (head_job.esc[grp] && !esc_done) begin
          esc_done <= 1'b1;
        end else begin
          esc_done <= 1'b0;
          if (grp == LAST_GROUP) begin
            grp <= 2'd0;
            in_break <= head_job.brk;
          end else begin
            grp <= grp + 2'd1;
          end
        end
      end else if (chars.ready) begin
        chars.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chars.out_char <= byte_next;
      chars.last_of_pixel <= last_next;
    end
  end

  `RTPC_ASSERT_NOW(a_break_clean, in_break, grp == 2'd0 && !esc_done, "break phase with group state left over")
  `RTPC_ASSERT_NEXT(a_pop_marks_last, pop, chars.valid && chars.last_of_pixel, "pixel retired without a last byte")

endmodule

// ----- hdl/rgb_to_printable_char_encoder.sv -----
// Top level of the RGB pixel to printable character encoder.
//
// Usage:
//   pixels : one RGB pixel per transaction (red, green, blue, image_start).
//   chars  : one ASCII byte per transaction; last_of_pixel marks the final
//            byte produced by a pixel.
//   cfg    : write of pixels_per_line (reset value 16); write it only while
//            no pixel is in flight. It is always ready.
// Each pixel yields its four characters (offset 6-bit groups, red MSB first),
// a backslash before any quote or backslash, and the quote/newline/tab/quote
// break after every pixels_per_line pixels; image_start restarts the count.
// A pixel is first written into the job queue, and its first byte is then
// loaded from the queue head into the output register.
// Throughput: one output byte per cycle while the queue holds a job and the
// receiver takes bytes; a pixel yields 4 to 12 bytes (4 plus escapes plus 4
// when it ends a line) from the back-end byte sequencer. The front end keeps taking pixels until
// the four-entry job queue fills, so input and output stall independently.
// Reset (rst, synchronous): empty the queue, clear the line count, restore
// pixels_per_line to 16. When the receiver stalls, hold the output byte and
// let the queue absorb pixels; pixels.ready drops only once it is full.
module rgb_to_printable_char_encoder import rtpc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  rtpc_pixel_if.sink   pixels,
  rtpc_char_if.source  chars,
  rtpc_cfg_if.sink     cfg
);

  // Front end pushes one classified job per accepted pixel.
  logic          push;
  job_t          push_job;
  // Back end retires a job as its final byte is loaded.
  logic          pop;
  job_t          head_job;
  queue_status_t q_status;

  rtpc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .pixels   (pixels),
    .cfg      (cfg),
    .q_status (q_status),
    .push     (push),
    .push_job (push_job)
  );

  // Decouple pixel intake from byte output.
  rtpc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_status (q_status)
  );

  rtpc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head_job (head_job),
    .q_status (q_status),
    .pop      (pop),
    .chars    (chars)
  );

endmodule
